// ----- rtl/core/pccs_pkg.sv -----
// ============================================================================
// pccs_pkg
// Types and constants for the point-charge cutoff scaler: beat payloads,
// register map and the scaling mode carried down the pipeline.
// ============================================================================
package pccs_pkg;

  localparam int unsigned INDEX_BITS = 20;
  localparam int unsigned ADDR_BITS  = 5;

  typedef struct packed {
    logic [INDEX_BITS-1:0] atom_index;
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic signed [31:0]    pos_z;
    logic signed [31:0]    charge_in;
    logic                  exclude;
  } item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] out_index;
    logic signed [31:0]    q_scaled;
    logic signed [31:0]    q_orig;
    logic signed [31:0]    out_x;
    logic signed [31:0]    out_y;
    logic signed [31:0]    out_z;
  } result_t;

  // Fields that ride along with every pipeline stage.
  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic signed [31:0]    q;
    logic signed [31:0]    x;
    logic signed [31:0]    y;
    logic signed [31:0]    z;
  } carry_t;

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_Z,
    REG_CUTOFF,
    REG_PERIODIC
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SCALE_PASS,
    SCALE_ZERO,
    SCALE_DIV
  } scale_mode_t;

  localparam logic signed [33:0] SAT_HI = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_LO = 34'sh3_8000_0000;

endpackage

// ----- rtl/core/point_charge_cutoff_scaler_top.sv -----
// ============================================================================
// point_charge_cutoff_scaler_top
// Minimum-image shift and quartic switching of point charges, one beat per
// clock while the skid register is empty, with an APB-style register port.
// ============================================================================
//
//  Channel  | Signals                                  | Direction
//  ---------+------------------------------------------+----------
//  item     | item_valid, item_ready, item (item_t)    | in
//  result   | result_valid, result_ready, result       | out
//  config   | psel, penable, pwrite, paddr, pwdata,    | in/out
//           | prdata, pready                           |
//
//  One charge enters per clock while the skid register is empty. A kept
//  charge passes S1..S6, the 32 one-bit stages of the restoring divider
//  that forms (c^2 - d^2) / c^2, M1 and M2 on its way to the output register.
//  Reset (rst, synchronous) empties the pipeline and clears all configuration registers.
//  The result port has an output register plus one skid register; the whole
//  pipeline halts only while the skid register is full, so nothing is lost
//  or repeated. item_ready is the inverse of the registered skid flag.
//
//  Stage plan: S1 offset from centre, S2 minimum-image shift with
//  saturation, S3 absolute offsets and the per-axis cutoff test, S4 squares,
//  S5 sum of squares, S6 classify and form the remainder, D1..D32 quotient
//  bits, M1 t*t, M2 |q|*f, then sign and output register.
module point_charge_cutoff_scaler_top
  import pccs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned DIV_STEPS = 32;

  // Configuration registers.
  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0]        box_x, box_y, box_z;
  logic [30:0]        cutoff_radius;
  logic               periodic_enable;

  cfg_reg_t reg_sel;
  assign reg_sel = cfg_reg_t'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      center_z        <= '0;
      box_x           <= '0;
      box_y           <= '0;
      box_z           <= '0;
      cutoff_radius   <= '0;
      periodic_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_CENTER_X: center_x        <= pwdata;
        REG_CENTER_Y: center_y        <= pwdata;
        REG_CENTER_Z: center_z        <= pwdata;
        REG_BOX_X:    box_x           <= pwdata[30:0];
        REG_BOX_Y:    box_y           <= pwdata[30:0];
        REG_BOX_Z:    box_z           <= pwdata[30:0];
        REG_CUTOFF:   cutoff_radius   <= pwdata[30:0];
        REG_PERIODIC: periodic_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CENTER_X: prdata = center_x;
      REG_CENTER_Y: prdata = center_y;
      REG_CENTER_Z: prdata = center_z;
      REG_BOX_X:    prdata = {1'b0, box_x};
      REG_BOX_Y:    prdata = {1'b0, box_y};
      REG_BOX_Z:    prdata = {1'b0, box_z};
      REG_CUTOFF:   prdata = {1'b0, cutoff_radius};
      REG_PERIODIC: prdata = {31'b0, periodic_enable};
      default:      prdata = '0;
    endcase
  end

  // Shift one coordinate by a box length when it is more than half a box
  // from the centre, then clamp to the signed 32-bit range.
  function automatic logic signed [31:0] min_image(
    input logic signed [31:0] p,
    input logic signed [32:0] d,
    input logic [30:0]        box
  );
    logic signed [33:0] twice;
    logic signed [33:0] b;
    logic signed [33:0] moved;
    begin
      twice = {d, 1'b0};
      b     = $signed({3'b000, box});
      if (twice > b) begin
        moved = {{2{p[31]}}, p} - b;
      end else if (twice < -b) begin
        moved = {{2{p[31]}}, p} + b;
      end else begin
        moved = {{2{p[31]}}, p};
      end
      if (moved > SAT_HI) begin
        min_image = SAT_HI[31:0];
      end else if (moved < SAT_LO) begin
        min_image = SAT_LO[31:0];
      end else begin
        min_image = moved[31:0];
      end
    end
  endfunction

  // Absolute value of a 33-bit signed offset; it always fits in 32 bits.
  function automatic logic [31:0] abs33(input logic signed [32:0] d);
    logic signed [32:0] m;
    begin
      m     = d[32] ? -d : d;
      abs33 = m[31:0];
    end
  endfunction

  // The whole pipeline moves together and halts only on a full skid register.
  logic en;
  logic skid_valid;
  assign en         = !skid_valid;
  assign item_ready = !skid_valid;

  // S1: offsets from the centre.
  logic               s1_valid;
  carry_t             s1_c;
  logic signed [32:0] s1_dx, s1_dy, s1_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid && !item.exclude;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_c.idx <= item.atom_index;
      s1_c.q   <= item.charge_in;
      s1_c.x   <= item.pos_x;
      s1_c.y   <= item.pos_y;
      s1_c.z   <= item.pos_z;
      s1_dx    <= {item.pos_x[31], item.pos_x} - {center_x[31], center_x};
      s1_dy    <= {item.pos_y[31], item.pos_y} - {center_y[31], center_y};
      s1_dz    <= {item.pos_z[31], item.pos_z} - {center_z[31], center_z};
    end
  end

  // S2: minimum-image shift.
  logic   s2_valid;
  carry_t s2_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c.idx <= s1_c.idx;
      s2_c.q   <= s1_c.q;
      s2_c.x   <= periodic_enable ? min_image(s1_c.x, s1_dx, box_x) : s1_c.x;
      s2_c.y   <= periodic_enable ? min_image(s1_c.y, s1_dy, box_y) : s1_c.y;
      s2_c.z   <= periodic_enable ? min_image(s1_c.z, s1_dz, box_z) : s1_c.z;
    end
  end

  // S3: absolute offsets of the shifted position and the per-axis test.
  logic        s3_valid;
  carry_t      s3_c;
  logic [30:0] s3_ax, s3_ay, s3_az;
  logic        s3_far;
  logic [31:0] abs_x, abs_y, abs_z;

  always_comb begin
    abs_x = abs33({s2_c.x[31], s2_c.x} - {center_x[31], center_x});
    abs_y = abs33({s2_c.y[31], s2_c.y} - {center_y[31], center_y});
    abs_z = abs33({s2_c.z[31], s2_c.z} - {center_z[31], center_z});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c   <= s2_c;
      s3_ax  <= abs_x[30:0];
      s3_ay  <= abs_y[30:0];
      s3_az  <= abs_z[30:0];
      s3_far <= (abs_x >= {1'b0, cutoff_radius}) || (abs_y >= {1'b0, cutoff_radius}) ||
                (abs_z >= {1'b0, cutoff_radius});
    end
  end

  // S4: squares, one multiplier per axis plus one for the cutoff.
  logic        s4_valid;
  carry_t      s4_c;
  logic        s4_far;
  logic [61:0] s4_sx, s4_sy, s4_sz, s4_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_c   <= s3_c;
      s4_far <= s3_far;
      s4_sx  <= 62'(s3_ax) * 62'(s3_ax);
      s4_sy  <= 62'(s3_ay) * 62'(s3_ay);
      s4_sz  <= 62'(s3_az) * 62'(s3_az);
      s4_c2  <= 62'(cutoff_radius) * 62'(cutoff_radius);
    end
  end

  // S5: squared distance.
  logic        s5_valid;
  carry_t      s5_c;
  logic        s5_far;
  logic [63:0] s5_s;
  logic [61:0] s5_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_c   <= s4_c;
      s5_far <= s4_far;
      s5_s   <= 64'(s4_sx) + 64'(s4_sy) + 64'(s4_sz);
      s5_c2  <= s4_c2;
    end
  end

  // S6 and the divider stages share arrays; entry 0 is S6.
  logic        dv_valid [0:DIV_STEPS];
  carry_t      dv_c     [0:DIV_STEPS];
  scale_mode_t dv_mode  [0:DIV_STEPS];
  logic [61:0] dv_rem   [0:DIV_STEPS];
  logic [61:0] dv_c2    [0:DIV_STEPS];
  logic [31:0] dv_t     [0:DIV_STEPS];

  scale_mode_t s6_mode;
  logic [63:0] s6_rem;

  always_comb begin
    s6_rem = 64'(s5_c2) - s5_s;
    if (cutoff_radius == '0) begin
      s6_mode = SCALE_PASS;
    end else if (s5_far || (s5_s >= 64'(s5_c2))) begin
      s6_mode = SCALE_ZERO;
    end else if (s5_s == '0) begin
      s6_mode = SCALE_PASS;
    end else begin
      s6_mode = SCALE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c[0]    <= s5_c;
      dv_mode[0] <= s6_mode;
      dv_rem[0]  <= s6_rem[61:0];
      dv_c2[0]   <= s5_c2;
      dv_t[0]    <= '0;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [62:0] rem2;
    logic        take;

    assign rem2 = {dv_rem[k], 1'b0};
    assign take = rem2 >= {1'b0, dv_c2[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c[k+1]    <= dv_c[k];
        dv_mode[k+1] <= dv_mode[k];
        dv_c2[k+1]   <= dv_c2[k];
        dv_t[k+1]    <= {dv_t[k][30:0], take};
        if (take) begin
          dv_rem[k+1] <= 62'(rem2 - {1'b0, dv_c2[k]});
        end else begin
          dv_rem[k+1] <= rem2[61:0];
        end
      end
    end
  end

  // M1: factor f = t*t / 2^32.
  logic        m1_valid;
  carry_t      m1_c;
  scale_mode_t m1_mode;
  logic [31:0] m1_f;
  logic [63:0] tt;

  assign tt = 64'(dv_t[DIV_STEPS]) * 64'(dv_t[DIV_STEPS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_c    <= dv_c[DIV_STEPS];
      m1_mode <= dv_mode[DIV_STEPS];
      m1_f    <= tt[63:32];
    end
  end

  // M2: magnitude |q|*f / 2^32, truncated.
  logic        m2_valid;
  carry_t      m2_c;
  scale_mode_t m2_mode;
  logic [31:0] m2_mag;
  logic [31:0] qm;
  logic [63:0] qf;

  assign qm = abs33({m1_c.q[31], m1_c.q});
  assign qf = 64'(qm) * 64'(m1_f);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_c    <= m1_c;
      m2_mode <= m1_mode;
      m2_mag  <= qf[63:32];
    end
  end

  // Sign and packing of the finished beat.
  result_t fin;

  always_comb begin
    fin.out_index = m2_c.idx;
    fin.q_orig    = m2_c.q;
    fin.out_x     = m2_c.x;
    fin.out_y     = m2_c.y;
    fin.out_z     = m2_c.z;
    case (m2_mode)
      SCALE_PASS: fin.q_scaled = m2_c.q;
      SCALE_ZERO: fin.q_scaled = '0;
      SCALE_DIV:  fin.q_scaled = m2_c.q[31] ? -m2_mag : m2_mag;
      default:    fin.q_scaled = '0;
    endcase
  end

  // Output register with one skid register behind it.
  result_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_valid && !result_ready) begin
      if (m2_valid && en) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else begin
      result_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && !result_ready) begin
      if (m2_valid && en) begin
        skid <= fin;
      end
    end else if (skid_valid) begin
      result <= skid;
    end else if (m2_valid) begin
      result <= fin;
    end
  end

`ifndef SYNTH
  // The skid register only fills behind a held output beat.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register full with empty output register");

  // A finished beat arriving at a stalled output must land in the skid.
  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready && !skid_valid && m2_valid) |=> skid_valid)
    else $error("finished beat not captured on stall");

  // Scaling never flips the sign of a charge.
  a_sign_kept: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.q_scaled == '0 ||
                      result.q_scaled[31] == result.q_orig[31]))
    else $error("scaled charge sign differs from original");
`endif

endmodule

// ----- sim/point_charge_cutoff_scaler_top_test.sv -----
// ============================================================================
// point_charge_cutoff_scaler_top_test
// Streams point charges through the cutoff scaler under several register
// settings, predicts every kept charge in the bench and compares each result
// beat in full, with random sender bursts and receiver stalls.
// ============================================================================
`timescale 1ns / 1ps

module point_charge_cutoff_scaler_top_test;
  import pccs_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 20000;
  localparam int unsigned DRAIN_CYCLES    = 60;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  point_charge_cutoff_scaler_top dut (.*);

  always #2 clk = ~clk;

  // Bench copy of the register file, updated as each write lands.
  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  logic [30:0]        len_x, len_y, len_z;
  logic [30:0]        cut_r;
  logic               wrap_on;

  item_t   pending_beats[$];
  result_t expected_charges[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      stall_hold = 1'b0;
  bit      long_stall_req = 1'b0;

  // Minimum-image shift of one axis, saturating at the 32-bit range.
  function automatic logic signed [31:0] wrap_axis(logic signed [31:0] p,
                                                   logic signed [31:0] c,
                                                   logic [30:0] len);
    longint d, b, v;
    d = longint'(p) - longint'(c);
    b = longint'({33'b0, len});
    v = p;
    if (2 * d > b) v = v - b;
    else if (2 * d < -b) v = v + b;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic result_t scale_charge(item_t it);
    result_t r;
    longint q, dx, dy, dz;
    logic [63:0] ax, ay, az, c, c2, s, rem, t, f, mag, qm;
    r.out_index = it.atom_index;
    r.q_orig    = it.charge_in;
    r.out_x = wrap_on ? wrap_axis(it.pos_x, ctr_x, len_x) : it.pos_x;
    r.out_y = wrap_on ? wrap_axis(it.pos_y, ctr_y, len_y) : it.pos_y;
    r.out_z = wrap_on ? wrap_axis(it.pos_z, ctr_z, len_z) : it.pos_z;
    q = it.charge_in;
    if (cut_r == 0) begin
      r.q_scaled = it.charge_in;
      return r;
    end
    dx = longint'(r.out_x) - longint'(ctr_x);
    dy = longint'(r.out_y) - longint'(ctr_y);
    dz = longint'(r.out_z) - longint'(ctr_z);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    c  = {33'b0, cut_r};
    c2 = c * c;
    r.q_scaled = '0;
    if (ax >= c || ay >= c || az >= c) return r;
    s = ax * ax + ay * ay + az * az;
    if (s >= c2) return r;
    if (s == 0) begin
      r.q_scaled = it.charge_in;
      return r;
    end
    rem = c2 - s;
    t = 0;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      t = t << 1;
      if (rem >= c2) begin
        rem = rem - c2;
        t[0] = 1'b1;
      end
    end
    f   = (t * t) >> 32;
    qm  = q < 0 ? -q : q;
    mag = (qm * f) >> 32;
    r.q_scaled = q < 0 ? -mag[31:0] : mag[31:0];
    return r;
  endfunction

  // Driver: bursts of beats with random gaps; valid holds until accepted.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        if (!item.exclude)
          expected_charges.insert(expected_charges.size(), scale_charge(item));
      end
      if (!item_valid || item_ready) begin
        if (item_valid && item_ready) void'(pending_beats.pop_front());
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          item_valid <= 1'b1;
          item <= pending_beats[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: runs of random length with ready or stall, plus one
  // long hold-off on request so the pipeline fills and backs up the input.
  int stall_run = 0;
  int hold_count = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (long_stall_req && hold_count == 0 && !stall_hold) begin
      stall_hold <= 1'b1;
      hold_count <= 300;
      result_ready <= 1'b0;
    end else if (stall_hold) begin
      if (hold_count == 1) stall_hold <= 1'b0;
      hold_count <= hold_count - 1;
      result_ready <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      stall_run <= $urandom_range(0, 12);
      result_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_charges.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result beat %p", result);
      end else begin
        result_t want;
        want = expected_charges.pop_front();
        if (want !== result) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: expected %p, got %p", want, result);
        end
      end
    end
  end

  // Watchdog: counts cycles with no accepted beat on either channel while work is pending, outside the long hold.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) || stall_hold)
      idle_cycles <= 0;
    else if (pending_beats.size() > 0 || expected_charges.size() > 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_BITS'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X: ctr_x = value;
      REG_CENTER_Y: ctr_y = value;
      REG_CENTER_Z: ctr_z = value;
      REG_BOX_X:    len_x = value[30:0];
      REG_BOX_Y:    len_y = value[30:0];
      REG_BOX_Z:    len_z = value[30:0];
      REG_CUTOFF:   cut_r = value[30:0];
      default:      wrap_on = value[0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0 || item_valid || expected_charges.size() > 0)
      @(posedge clk);
    // Excluded beats make no result but may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                               logic [31:0] cr, logic pe);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_BOX_X, bx);
    write_reg(REG_BOX_Y, by);
    write_reg(REG_BOX_Z, bz);
    write_reg(REG_CUTOFF, cr);
    write_reg(REG_PERIODIC, {31'b0, pe});
  endtask

  // Random charge near the centre so that both shifts and the cutoff test
  // are exercised; about one coordinate in four is fully random.
  function automatic logic [31:0] near(logic [31:0] c, int unsigned spread);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return c + $urandom_range(0, 2 * spread) - spread;
  endfunction

  function automatic void add_beat(item_t it);
    pending_beats.insert(pending_beats.size(), it);
  endfunction

  task automatic queue_random(int n, int unsigned spread);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.atom_index = INDEX_BITS'($urandom);
      it.pos_x = near(ctr_x, spread);
      it.pos_y = near(ctr_y, spread);
      it.pos_z = near(ctr_z, spread);
      it.charge_in = ($urandom_range(0, 7) == 0) ? {$urandom_range(0, 1) ? 32'h8000_0000
                                                   : 32'h7FFF_FFFF} : $urandom;
      it.exclude = ($urandom_range(0, 9) == 0);
      add_beat(it);
    end
  endtask

  function automatic item_t mk(logic [19:0] ix, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [31:0] q, logic ex);
    item_t it;
    it.atom_index = ix; it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.charge_in = q; it.exclude = ex;
    return it;
  endfunction

  initial begin
    ctr_x = 0; ctr_y = 0; ctr_z = 0;
    len_x = 0; len_y = 0; len_z = 0;
    cut_r = 0; wrap_on = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats at reset settings: pass-through, extremes, exclusion.
    add_beat(mk(20'hFFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 1'b0));
    add_beat(mk(20'd0, 0, 0, 0, 32'h7FFF_FFFF, 1'b0));
    add_beat(mk(20'h12345, 1, 2, 3, 32'h0001_0000, 1'b1));
    wait_drained();

    // Periodic with maximum X and Y boxes and a cutoff; centre at an extreme.
    apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0010_0000, 32'h7FFF_FFFF, 1'b1);
    add_beat(mk(20'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0009_0000, 32'h8000_0000, 1'b0));
    add_beat(mk(20'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF7_0000, 32'h7FFF_FFFF, 1'b0));
    add_beat(mk(20'd3, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0001_0000, 1'b0));
    add_beat(mk(20'd4, 0, 0, 32'h0008_0000, 32'hFFFF_0000, 1'b0));
    wait_drained();

    // Small cutoff and box at the centre: on the boundary, inside, zero box.
    apply_setting(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0004_0000, 0,
                  32'h0004_0000, 32'h0001_0000, 1'b1);
    add_beat(mk(20'd5, 32'h0002_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000, 1'b0));
    add_beat(mk(20'd6, 32'h0001_8000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0));
    add_beat(mk(20'd7, 32'h0001_0001, 32'h7FFF_FFFF, 32'h0002_0000, 32'h7FFF_FFFF, 1'b0));
    add_beat(mk(20'd8, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000, 1'b0));
    add_beat(mk(20'd9, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h1234_5678, 1'b1));
    wait_drained();

    // Random phases across settings; the first gets the long receiver hold.
    apply_setting(0, 0, 0, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
                  32'h0004_0000, 1'b1);
    long_stall_req = 1'b1;
    queue_random(150, 32'h0008_0000);
    wait (stall_hold);
    long_stall_req = 1'b0;
    wait_drained();

    apply_setting($urandom, $urandom, $urandom, $urandom_range(0, 32'h0040_0000),
                  $urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000),
                  $urandom_range(1, 32'h0020_0000), 1'b1);
    queue_random(150, 32'h0020_0000);
    wait_drained();

    apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 1'b0);
    queue_random(100, 32'h0100_0000);
    wait_drained();

    apply_setting(32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_0000, 32'h0000_0001,
                  32'h7FFF_FFFF, 32'h0003_0000, 32'h7FFF_FFFF, 1'b0);
    queue_random(135, 32'h4000_0000);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
